// ===== rtl/core/mts_pkg.sv =====
// Shared types and constants for the markup tag stripper.
package mts_pkg;

  localparam int ByteW   = 8;
  localparam int CountW  = 16;
  localparam int CfgDataW = 32;
  localparam int CfgAddrW = 3;

  localparam logic [ByteW-1:0] ChOpen  = 8'h3C;
  localparam logic [ByteW-1:0] ChClose = 8'h3E;
  localparam logic [ByteW-1:0] ChNl    = 8'h0A;
  localparam logic [ByteW-1:0] ChP     = 8'h70;
  localparam logic [ByteW-1:0] ChB     = 8'h62;
  localparam logic [ByteW-1:0] ChR     = 8'h72;
  localparam logic [ByteW-1:0] ChSlash = 8'h2F;
  localparam logic [ByteW-1:0] ChD     = 8'h64;
  localparam logic [ByteW-1:0] ChI     = 8'h69;
  localparam logic [ByteW-1:0] ChV     = 8'h76;

  localparam logic [CountW-1:0] OutputLimitReset = 16'd16382;

  localparam logic RegOutputLimit = 1'b0;

  typedef enum logic [3:0] {
    MATCH_NONE = 4'd0,
    MATCH_LT   = 4'd1,
    MATCH_P    = 4'd2,
    MATCH_B    = 4'd3,
    MATCH_BR   = 4'd4,
    MATCH_SL   = 4'd5,
    MATCH_D    = 4'd6,
    MATCH_DI   = 4'd7,
    MATCH_DIV  = 4'd8
  } match_t;

  typedef struct packed {
    logic              fire;
    logic [ByteW-1:0]  data;
    logic [CountW-1:0] count;
  } trk_result_t;

endpackage

// ===== rtl/core/markup_tag_stripper_unit.sv =====
// Markup tag stripper: an input register, the tag tracker and a result register.
// The block takes one page byte per cycle while the output does not stall and passes on
// the bytes that lie outside angle-bracket tags; the tags <p>, <br> and </div> each
// give one newline at their closing bracket, and at most output_limit results appear
// per page. A byte is registered in the input register on transfer and evaluated against
// the tag state while it sits there; its result, if any, is then registered in the
// result register and offered from it, and the tag state updates as the byte moves on.
// A new byte is taken while a result waits, until both registers are full.
module markup_tag_stripper_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mts_pkg::ByteW-1:0]     in_page_byte,
  input  logic                          in_page_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mts_pkg::ByteW-1:0]     out_text_byte,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mts_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [mts_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [mts_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  logic                         stg_valid_r;
  logic [mts_pkg::ByteW-1:0]    stg_byte_r;
  logic                         stg_start_r;
  logic                         out_valid_r;
  logic [mts_pkg::ByteW-1:0]    out_byte_r;
  logic                         out_free;
  logic                         stg_go;
  logic                         in_take;
  logic [mts_pkg::CountW-1:0]   output_limit;
  mts_pkg::trk_result_t         trk_res;

  mts_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .output_limit (output_limit)
  );

  mts_tag_tracker u_trk (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (stg_go),
    .page_byte    (stg_byte_r),
    .page_start   (stg_start_r),
    .output_limit (output_limit),
    .result       (trk_res)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign stg_go    = stg_valid_r && out_free;
  assign in_stall  = stg_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_take) begin
      stg_valid_r <= 1'b1;
    end else if (stg_go) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_byte_r  <= in_page_byte;
      stg_start_r <= in_page_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= stg_go && trk_res.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stg_go && trk_res.fire) begin
      out_byte_r <= trk_res.data;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_byte = out_byte_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (stg_valid_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline had room");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_go && trk_res.fire) |=> (out_valid_r && (out_byte_r == $past(trk_res.data))))
    else $error("evaluated result did not reach the output register");

  a_page_start_count: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_go && stg_start_r) |=> (trk_res.count <= 16'd1))
    else $error("page start did not clear the output count");

  a_no_fire_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_go && !trk_res.fire) |=> !out_valid_r)
    else $error("result appeared for a byte that produces none");
`endif

endmodule

// ===== rtl/core/mts_cfg_regs.sv =====
// Configuration register file with the APB-style write and read port.
module mts_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mts_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [mts_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [mts_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready,
  output logic [mts_pkg::CountW-1:0]    output_limit
);

  logic [mts_pkg::CountW-1:0] limit_r;
  logic                       reg_idx;
  logic                       wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= mts_pkg::OutputLimitReset;
    end else if (wr_en && (reg_idx == mts_pkg::RegOutputLimit)) begin
      limit_r <= cfg_pwdata[mts_pkg::CountW-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_idx == mts_pkg::RegOutputLimit) begin
      cfg_prdata = {{(mts_pkg::CfgDataW-mts_pkg::CountW){1'b0}}, limit_r};
    end
  end

  assign output_limit = limit_r;

endmodule

// ===== rtl/core/mts_tag_tracker.sv =====
// Tag state, incremental tag matching and the per-page output count.
module mts_tag_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [mts_pkg::ByteW-1:0]    page_byte,
  input  logic                         page_start,
  input  logic [mts_pkg::CountW-1:0]   output_limit,
  output mts_pkg::trk_result_t         result
);

  logic                        in_tag_r, in_tag_nxt;
  mts_pkg::match_t             step_r, step_nxt;
  logic [mts_pkg::CountW-1:0]  count_r, count_nxt;
  logic                        tag_cur;
  mts_pkg::match_t             step_cur;
  logic [mts_pkg::CountW-1:0]  count_cur;
  logic                        emit;
  logic [mts_pkg::ByteW-1:0]   val;

  function automatic mts_pkg::match_t next_match(input mts_pkg::match_t s,
                                                 input logic [7:0] c);
    mts_pkg::match_t r;
    r = mts_pkg::MATCH_NONE;
    case (s)
      mts_pkg::MATCH_LT: begin
        if (c == mts_pkg::ChP) r = mts_pkg::MATCH_P;
        else if (c == mts_pkg::ChB) r = mts_pkg::MATCH_B;
        else if (c == mts_pkg::ChSlash) r = mts_pkg::MATCH_SL;
      end
      mts_pkg::MATCH_B:  if (c == mts_pkg::ChR) r = mts_pkg::MATCH_BR;
      mts_pkg::MATCH_SL: if (c == mts_pkg::ChD) r = mts_pkg::MATCH_D;
      mts_pkg::MATCH_D:  if (c == mts_pkg::ChI) r = mts_pkg::MATCH_DI;
      mts_pkg::MATCH_DI: if (c == mts_pkg::ChV) r = mts_pkg::MATCH_DIV;
      default: r = mts_pkg::MATCH_NONE;
    endcase
    return r;
  endfunction

  always_comb begin
    tag_cur   = page_start ? 1'b0 : in_tag_r;
    step_cur  = page_start ? mts_pkg::MATCH_NONE : step_r;
    count_cur = page_start ? '0 : count_r;
    emit      = 1'b0;
    val       = page_byte;
    in_tag_nxt = tag_cur;
    step_nxt   = step_cur;
    if (page_byte == mts_pkg::ChOpen) begin
      in_tag_nxt = 1'b1;
      step_nxt   = mts_pkg::MATCH_LT;
    end else if (page_byte == mts_pkg::ChClose) begin
      emit = tag_cur && ((step_cur == mts_pkg::MATCH_P) || (step_cur == mts_pkg::MATCH_BR) ||
                         (step_cur == mts_pkg::MATCH_DIV));
      val        = mts_pkg::ChNl;
      in_tag_nxt = 1'b0;
      step_nxt   = mts_pkg::MATCH_NONE;
    end else if (tag_cur) begin
      step_nxt = next_match(step_cur, page_byte);
    end else begin
      emit = 1'b1;
    end
    result.fire  = emit && (count_cur < output_limit);
    result.data  = val;
    count_nxt    = result.fire ? count_cur + 1'b1 : count_cur;
    result.count = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_tag_r <= 1'b0;
      step_r   <= mts_pkg::MATCH_NONE;
      count_r  <= '0;
    end else if (advance) begin
      in_tag_r <= in_tag_nxt;
      step_r   <= step_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== dv/tb.sv =====
// Testbench for markup_tag_stripper_unit: random pages with tags, scoreboard check.
`timescale 1ns / 100ps

module tb;
  import mts_pkg::*;

  localparam int CycleLimit = 400000;
  localparam logic [CfgAddrW-1:0] LimitAddr = CfgAddrW'(4 * RegOutputLimit);

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             s;
  } page_item_t;

  class text_scoreboard;
    logic [CountW-1:0] limit;
    logic              in_tag;
    match_t            step;
    logic [CountW-1:0] count;
    logic [ByteW-1:0]  text_q[$];
    int                errors;

    function new();
      limit = OutputLimitReset;
      in_tag = 1'b0;
      step = MATCH_NONE;
      count = '0;
      errors = 0;
    endfunction

    function match_t next_step(match_t s, logic [ByteW-1:0] c);
      case (s)
        MATCH_LT: begin
          if (c == ChP) return MATCH_P;
          if (c == ChB) return MATCH_B;
          if (c == ChSlash) return MATCH_SL;
          return MATCH_NONE;
        end
        MATCH_B:  return (c == ChR) ? MATCH_BR : MATCH_NONE;
        MATCH_SL: return (c == ChD) ? MATCH_D : MATCH_NONE;
        MATCH_D:  return (c == ChI) ? MATCH_DI : MATCH_NONE;
        MATCH_DI: return (c == ChV) ? MATCH_DIV : MATCH_NONE;
        default:  return MATCH_NONE;
      endcase
    endfunction

    function void note_byte(logic [ByteW-1:0] c, logic start);
      logic             emit;
      logic [ByteW-1:0] val;
      emit = 1'b0;
      val = '0;
      if (start) begin
        in_tag = 1'b0;
        step = MATCH_NONE;
        count = '0;
      end
      if (c == ChOpen) begin
        in_tag = 1'b1;
        step = MATCH_LT;
      end else if (c == ChClose) begin
        if (in_tag && (step == MATCH_P || step == MATCH_BR || step == MATCH_DIV)) begin
          emit = 1'b1;
          val = ChNl;
        end
        in_tag = 1'b0;
        step = MATCH_NONE;
      end else if (in_tag) begin
        step = next_step(step, c);
      end else begin
        emit = 1'b1;
        val = c;
      end
      if (emit && count < limit) begin
        count = count + 1'b1;
        text_q.push_back(val);
      end
    endfunction

    function void check_text(logic [ByteW-1:0] got);
      logic [ByteW-1:0] want;
      if (text_q.size() == 0) begin
        $display("%0t: unexpected text_byte, expected none, got %02h", $time, got);
        errors++;
      end else begin
        want = text_q.pop_front();
        if (got !== want) begin
          $display("%0t: text_byte mismatch, expected %02h, got %02h", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ByteW-1:0]    in_page_byte = '0;
  logic                in_page_start = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ByteW-1:0]    out_text_byte;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [CfgDataW-1:0] cfg_pwdata = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  text_scoreboard sb;
  page_item_t     plan_q[$];
  logic           next_start;
  int             idle_pct = 0;
  int             stall_pct = 0;
  int             cycles = 0;
  string          tag_names[3] = '{"<p>", "<br>", "</div>"};

  markup_tag_stripper_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_page_byte  (in_page_byte),
    .in_page_start (in_page_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_text_byte (out_text_byte),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Inputs change only at rising edges, so the values seen at the falling edge
  // decide whether a transfer happens at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_text(out_text_byte);
    end
  end

  task plan_byte(input logic [ByteW-1:0] c);
    plan_q.push_back('{b: c, s: next_start});
    next_start = 1'b0;
  endtask

  task plan_text(input string t);
    int i;
    for (i = 0; i < t.len(); i++) begin
      plan_byte(t[i]);
    end
  endtask

  function logic [ByteW-1:0] text_char();
    logic [ByteW-1:0] c;
    c = ByteW'($urandom_range(255));
    if (c == ChOpen || c == ChClose) begin
      c = c ^ 8'h01;
    end
    return c;
  endfunction

  task plan_token();
    int    kind;
    int    k;
    int    i;
    string t;
    kind = $urandom_range(99);
    if ($urandom_range(99) < 4) begin
      next_start = 1'b1;
    end
    t = tag_names[$urandom_range(2)];
    if (kind < 40) begin
      plan_byte(text_char());
    end else if (kind < 60) begin
      plan_text(t);
    end else if (kind < 70) begin
      k = $urandom_range(t.len() - 2, 1);
      for (i = 0; i < k; i++) begin
        plan_byte(t[i]);
      end
      plan_byte(ByteW'($urandom_range(255)));
      plan_byte(ChClose);
    end else if (kind < 80) begin
      plan_byte(ChOpen);
      repeat ($urandom_range(4)) plan_byte(ByteW'($urandom_range(255)));
      plan_byte(ChClose);
    end else if (kind < 86) begin
      plan_byte(ChClose);
    end else if (kind < 92) begin
      plan_byte(ChOpen);
      plan_byte(ByteW'($urandom_range(255)));
      plan_text(t);
    end else if (kind < 95) begin
      k = $urandom_range(t.len() - 1, 1);
      for (i = 0; i < k; i++) begin
        plan_byte(t[i]);
      end
      next_start = 1'b1;
    end else begin
      plan_byte(ByteW'($urandom_range(255)));
    end
  endtask

  task send_plan();
    page_item_t it;
    while (plan_q.size() > 0) begin
      it = plan_q.pop_front();
      while ($urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_page_byte <= it.b;
      in_page_start <= it.s;
      forever begin
        @(negedge clk);
        if (!in_stall) break;
        @(posedge clk);
      end
      sb.note_byte(it.b, it.s);
      @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  task drain();
    while (sb.text_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_limit(input logic [CountW-1:0] v);
    logic rdy;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= LimitAddr;
    cfg_pwdata <= CfgDataW'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = cfg_pready;
      @(posedge clk);
    end while (!rdy);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.limit = v;
  endtask

  task run_phase(input int n, input int idle, input int stall, input logic [CountW-1:0] lim);
    drain();
    write_limit(lim);
    idle_pct = idle;
    stall_pct = stall;
    next_start = 1'b1;
    while (plan_q.size() < n) plan_token();
    send_plan();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    next_start = 1'b1;
    plan_byte(8'h00);
    plan_byte(8'hFF);
    plan_text("<p><br></div>>");
    plan_text("<<p><P>");
    plan_text("<br");
    next_start = 1'b1;
    plan_text("z");
    send_plan();

    run_phase(170, 0, 0, 16'hFFFF);
    run_phase(40, 29, 29, 16'h0000);
    run_phase(170, 64, 0, 16'd7);
    run_phase(170, 0, 64, CountW'($urandom_range(40, 1)));
    run_phase(170, 29, 29, CountW'($urandom_range(65535)));

    stall_pct = 0;
    drain();
    if (sb.errors == 0 && sb.text_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
